/* rtl/rse_pkg.sv */
`timescale 1ns / 1ps

package rse_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_W         = 32;
    localparam int DEPTH_W         = 8;
    localparam int CMD_W           = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SUB     = 3'd2,
        CMD_MUL     = 3'd3,
        CMD_DIV     = 3'd4,
        CMD_REM     = 3'd5,
        CMD_POP     = 3'd6,
        CMD_UNKNOWN = 3'd7
    } t_cmd;

endpackage

/* rtl/rse_in_if.sv */
`timescale 1ns / 1ps

interface rse_in_if
    import rse_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] operand;

    modport source (output valid, output cmd, output operand, input ready);
    modport sink   (input valid, input cmd, input operand, output ready);
endinterface

/* rtl/rse_out_if.sv */
`timescale 1ns / 1ps

interface rse_out_if
    import rse_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      empty_error;
    logic                      full_error;
    logic                      zero_divisor;
    logic                      unknown_command;
    logic                      saturated;
    logic [DEPTH_W-1:0]        depth;

    modport source (
        output valid, output value, output empty_error, output full_error,
        output zero_divisor, output unknown_command, output saturated,
        output depth, input ready
    );
    modport sink (
        input valid, input value, input empty_error, input full_error,
        input zero_divisor, input unknown_command, input saturated,
        input depth, output ready
    );
endinterface

/* rtl/rpn_stack_evaluator_core.sv */
`timescale 1ns / 1ps
// Channel | Dir | Payload                                   | Request taken when
// i_in    | in  | cmd, operand                              | valid && ready
// o_out   | out | value, five error flags, depth            | valid && ready
//
// Requests are handled one at a time; the stack lives in a RAM with one read port.
// A push writes the stack and a pop reads the top. Add, subtract and multiply pop two
// operands and push the result; divide and remainder wait on the divider, which retires
// one quotient bit a cycle. A zero divisor or an unknown token skips the push.
// Reset clears the stack pointer and the handshake state; the RAM is not cleared.
// A finished result waits in the output register while the next request is taken.

module rpn_stack_evaluator_core
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rse_in_if.sink    i_in,
    rse_out_if.source o_out
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int DVD_W = VALUE_W + FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_POP_B, S_WAIT_B, S_POP_A, S_WAIT_A,
        S_EXEC, S_MUL, S_DIV, S_PUSH, S_DONE
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               sat;
    } t_clamp;

    function automatic t_clamp clamp_mag(input logic neg, input logic [63:0] mag);
        t_clamp res;
        res.sat = 1'b0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                res.sat   = 1'b1;
                res.value = 32'h8000_0000;
            end else begin
                res.value = 32'(32'd0 - mag[31:0]);
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                res.sat   = 1'b1;
                res.value = 32'h7FFF_FFFF;
            end else begin
                res.value = mag[31:0];
            end
        end
        return res;
    endfunction

    function automatic t_clamp clamp_sum(input logic [VALUE_W:0] sum);
        t_clamp res;
        res.sat = sum[VALUE_W] != sum[VALUE_W-1];
        if (res.sat) begin
            res.value = sum[VALUE_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res.value = sum[VALUE_W-1:0];
        end
        return res;
    endfunction

    t_state             r_state;
    t_cmd               r_cmd;
    logic [SPW-1:0]     r_sp;
    logic               r_hit;
    logic [VALUE_W-1:0] r_a;
    logic [VALUE_W-1:0] r_b;
    logic [63:0]        r_prod;
    logic [VALUE_W-1:0] r_res;
    logic               r_empty;
    logic               r_full;
    logic               r_zdiv;
    logic               r_unk;
    logic               r_sat;

    logic               r_ov;
    logic [VALUE_W-1:0] r_o_value;
    logic               r_o_empty;
    logic               r_o_full;
    logic               r_o_zdiv;
    logic               r_o_unk;
    logic               r_o_sat;
    logic [DEPTH_W-1:0] r_o_depth;

    logic [SPW-1:0]     n_sp_dec;
    logic               n_room;
    logic               n_rd_en;
    logic               n_wr_en;
    logic [VALUE_W-1:0] n_rd_data;
    logic [VALUE_W-1:0] n_pop_val;
    logic [VALUE_W-1:0] n_mag_a;
    logic [VALUE_W-1:0] n_mag_b;
    logic               n_a_neg;
    logic               n_b_neg;
    logic               n_div_start;
    logic [DVD_W-1:0]   n_dividend;
    logic               n_div_done;
    logic [DVD_W-1:0]   n_quo;
    logic [VALUE_W-1:0] n_rem;
    logic               n_accept;
    logic               n_load;
    t_clamp             n_sum_c;
    t_clamp             n_mul_c;
    t_clamp             n_div_c;

    always_comb begin
        n_sp_dec    = r_sp - SPW'(1);
        n_room      = r_sp < SPW'(STACK_DEPTH);
        n_rd_en     = (r_state == S_POP_B || r_state == S_POP_A) && r_sp != '0;
        n_wr_en     = r_state == S_PUSH && n_room;
        n_pop_val   = r_hit ? n_rd_data : '0;
        n_a_neg     = r_a[VALUE_W-1];
        n_b_neg     = r_b[VALUE_W-1];
        n_mag_a     = n_a_neg ? VALUE_W'(32'd0 - r_a) : r_a;
        n_mag_b     = n_b_neg ? VALUE_W'(32'd0 - r_b) : r_b;
        n_div_start = r_state == S_EXEC && (r_cmd == CMD_DIV || r_cmd == CMD_REM);
        n_dividend  = (r_cmd == CMD_DIV) ? (DVD_W'(n_mag_a) << FRAC_BITS) : DVD_W'(n_mag_a);
        n_accept    = i_in.valid && i_in.ready;
        n_load      = r_state == S_DONE && (!r_ov || o_out.ready);
        n_sum_c     = clamp_sum((r_cmd == CMD_SUB)
                                ? ({r_a[VALUE_W-1], r_a} - {r_b[VALUE_W-1], r_b})
                                : ({r_a[VALUE_W-1], r_a} + {r_b[VALUE_W-1], r_b}));
        n_mul_c     = clamp_mag(n_a_neg != n_b_neg, r_prod >> FRAC_BITS);
        n_div_c     = (r_cmd == CMD_DIV) ? clamp_mag(n_a_neg != n_b_neg, 64'(n_quo))
                                         : clamp_mag(n_a_neg, 64'(n_rem));
    end

    assign i_in.ready = r_state == S_IDLE;

    rse_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr_en),
        .i_wr_addr (r_sp[AW-1:0]),
        .i_wr_data (r_res),
        .i_rd_en   (n_rd_en),
        .i_rd_addr (n_sp_dec[AW-1:0]),
        .o_rd_data (n_rd_data)
    );

    rse_divider #(
        .DVD_W (DVD_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (n_div_start),
        .i_dividend  (n_dividend),
        .i_divisor   (n_mag_b),
        .o_done      (n_div_done),
        .o_quotient  (n_quo),
        .o_remainder (n_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (n_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_cmd   <= t_cmd'(i_in.cmd);
                        r_res   <= (t_cmd'(i_in.cmd) == CMD_PUSH) ? i_in.operand : '0;
                        r_empty <= 1'b0;
                        r_full  <= 1'b0;
                        r_zdiv  <= 1'b0;
                        r_unk   <= t_cmd'(i_in.cmd) == CMD_UNKNOWN;
                        r_sat   <= 1'b0;
                        unique case (t_cmd'(i_in.cmd))
                            CMD_PUSH: begin
                                r_state <= S_PUSH;
                            end
                            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REM, CMD_POP: begin
                                r_state <= S_POP_B;
                            end
                            CMD_UNKNOWN: begin
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_POP_B, S_POP_A: begin
                    r_hit <= r_sp != '0;
                    if (r_sp != '0) begin
                        r_sp <= n_sp_dec;
                    end else begin
                        r_empty <= 1'b1;
                    end
                    r_state <= (r_state == S_POP_B) ? S_WAIT_B : S_WAIT_A;
                end
                S_WAIT_B: begin
                    r_b <= n_pop_val;
                    if (r_cmd == CMD_POP) begin
                        r_res   <= n_pop_val;
                        r_state <= S_DONE;
                    end else if ((r_cmd == CMD_DIV || r_cmd == CMD_REM) && n_pop_val == '0) begin
                        r_zdiv  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_POP_A;
                    end
                end
                S_WAIT_A: begin
                    r_a     <= n_pop_val;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (r_cmd == CMD_ADD || r_cmd == CMD_SUB) begin
                        r_res   <= n_sum_c.value;
                        r_sat   <= n_sum_c.sat;
                        r_state <= S_PUSH;
                    end else if (r_cmd == CMD_MUL) begin
                        r_prod  <= n_mag_a * n_mag_b;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_MUL: begin
                    r_res   <= n_mul_c.value;
                    r_sat   <= n_mul_c.sat;
                    r_state <= S_PUSH;
                end
                S_DIV: begin
                    if (n_div_done) begin
                        r_res   <= n_div_c.value;
                        r_sat   <= n_div_c.sat;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (n_room) begin
                        r_sp <= r_sp + SPW'(1);
                    end else begin
                        r_full <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (n_load) begin
                        r_o_value <= r_res;
                        r_o_empty <= r_empty;
                        r_o_full  <= r_full;
                        r_o_zdiv  <= r_zdiv;
                        r_o_unk   <= r_unk;
                        r_o_sat   <= r_sat;
                        r_o_depth <= DEPTH_W'(r_sp);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.value           = r_o_value;
    assign o_out.empty_error     = r_o_empty;
    assign o_out.full_error      = r_o_full;
    assign o_out.zero_divisor    = r_o_zdiv;
    assign o_out.unknown_command = r_o_unk;
    assign o_out.saturated       = r_o_sat;
    assign o_out.depth           = r_o_depth;

endmodule

/* rtl/rse_stack_ram.sv */
`timescale 1ns / 1ps

module rse_stack_ram
    import rse_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [VALUE_W-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [VALUE_W-1:0] o_rd_data
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/rse_divider.sv */
`timescale 1ns / 1ps

module rse_divider
    import rse_pkg::*;
#(
    parameter int DVD_W = VALUE_W + FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dividend,
    input  logic [VALUE_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DVD_W-1:0]   o_quotient,
    output logic [VALUE_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DVD_W-1:0]   r_quo;
    logic [VALUE_W-1:0] r_rem;
    logic [VALUE_W-1:0] r_dvs;
    logic [VALUE_W:0]   n_shift;
    logic               n_ge;

    always_comb begin
        n_shift = {r_rem, r_quo[DVD_W-1]};
        n_ge    = n_shift >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DVD_W-2:0], n_ge};
                r_rem <= n_ge ? VALUE_W'(n_shift - {1'b0, r_dvs}) : n_shift[VALUE_W-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
